// File: hdl/lrpc_pkg.sv
// Shared types, field layouts and constants of the lidar range-to-point converter.
`default_nettype none

package lrpc_pkg;

  localparam int RANGE_W    = 24;
  localparam int DIR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int INT_W      = 8;
  localparam int COORD_W    = 25;
  localparam int STEP_W     = 13;
  localparam int SIZE_W     = 14;
  localparam int ENTRY_W    = 13;
  localparam int PROD_W     = RANGE_W + 1 + DIR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 120;

  localparam logic [SIZE_W-1:0]  SIZE_RESET   = 14'd8192;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 24'hFFFFFF;

  // Input beat layout, lowest bit first.
  localparam int IN_ENTRY_LSB = 0;
  localparam int IN_DIRX_LSB  = IN_ENTRY_LSB + ENTRY_W;
  localparam int IN_DIRY_LSB  = IN_DIRX_LSB + DIR_W;
  localparam int IN_DIRZ_LSB  = IN_DIRY_LSB + DIR_W;
  localparam int IN_TIME_LSB  = IN_DIRZ_LSB + DIR_W;
  localparam int IN_RANGE_LSB = IN_TIME_LSB + TIME_W;
  localparam int IN_INT_LSB   = IN_RANGE_LSB + RANGE_W;
  localparam int IN_USED_W    = IN_INT_LSB + INT_W;

  // Output beat layout, lowest bit first.
  localparam int OUT_X_LSB    = 0;
  localparam int OUT_Y_LSB    = OUT_X_LSB + COORD_W;
  localparam int OUT_Z_LSB    = OUT_Y_LSB + COORD_W;
  localparam int OUT_REFL_LSB = OUT_Z_LSB + COORD_W;
  localparam int OUT_TIME_LSB = OUT_REFL_LSB + INT_W;
  localparam int OUT_USED_W   = OUT_TIME_LSB + TIME_W;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SIZE  = 3'd4;

  typedef struct packed {
    logic               pass;
    logic               last;
    logic [INT_W-1:0]   refl;
    logic [RANGE_W-1:0] range;
  } s1_info_t;

  typedef struct packed {
    logic                      pass;
    logic                      last;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [INT_W-1:0]          refl;
    logic [TIME_W-1:0]         ptime;
  } point_t;

endpackage

`default_nettype wire

// File: hdl/lidar_range_to_point_converter.sv
// Top level of the lidar range-to-point converter with its scan pattern tables.
// A range sample accepted passes the sample stage, the product stage and the output register before its point shows.
// Throughput: one beat per cycle, loads included, while out_tready is high and no index reduction runs.
// After a write to scan_step, sample_stride or pattern_size the bit-serial remainder
// unit holds in_tready low until it has reduced the indexes and increments.
// Reset clears indexes and loads register defaults; tables are undefined until loaded.
`default_nettype none

module lidar_range_to_point_converter #(
  parameter int PATTERN_DEPTH = 8192,
  parameter int DIR_FRAC_BITS = 15
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // entry_index, dir_x, dir_y, dir_z, entry_time, range_mm, intensity, zero fill
  input  wire logic [lrpc_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd
  input  wire logic                                in_tuser,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // point_x, point_y, point_z, reflectivity, point_time, zero fill
  output logic      [lrpc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // point_valid
  output logic                                     out_tuser,
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lrpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lrpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(PATTERN_DEPTH);
  localparam int SW = AW + 1;
  localparam int DW = (AW > lrpc_pkg::STEP_W) ? AW : lrpc_pkg::STEP_W;
  localparam int DIRS_W = 3 * lrpc_pkg::DIR_W;
  localparam logic [SW-1:0] EFF_RESET = (PATTERN_DEPTH < 8192) ? SW'(PATTERN_DEPTH)
                                        : SW'(lrpc_pkg::SIZE_RESET);

  logic [lrpc_pkg::RANGE_W-1:0] min_r;
  logic [lrpc_pkg::RANGE_W-1:0] max_r;
  logic [lrpc_pkg::STEP_W-1:0]  step_r;
  logic [lrpc_pkg::STEP_W-1:0]  stride_r;
  logic [SW-1:0]                eff_size_r;
  logic [SW-1:0]                eff_size_nxt;
  logic                         start_r;
  logic                         reindex;

  logic [AW-1:0] ss_raw_r;
  logic [AW-1:0] ri_raw_r;
  logic [AW-1:0] ss_mod_r;
  logic [AW-1:0] ri_mod_r;
  logic [AW-1:0] stride_mod_r;
  logic [AW-1:0] step_mod_r;
  logic [AW-1:0] idx;
  logic [AW-1:0] ss_adv;
  logic [AW-1:0] ri_adv;
  logic [SW-1:0] idx_sum;
  logic [SW-1:0] ss_sum;
  logic [SW-1:0] ri_sum;

  logic                         mod_busy;
  logic                         mod_done;
  logic [3:0][DW-1:0]           mod_dvd;
  logic [3:0][AW-1:0]           mod_rem;
  logic [lrpc_pkg::STEP_W-1:0]  stride_eff;
  logic                         cfg_busy;

  logic                         cfg_beat;
  logic                         in_beat;
  logic                         sample_beat;
  logic                         load_ok;
  logic                         adv;
  logic [lrpc_pkg::ENTRY_W-1:0] entry_index;
  logic [lrpc_pkg::RANGE_W-1:0] range_mm;
  logic                         gate_pass;
  logic [AW-1:0]                ram_addr;
  logic                         ram_en;
  logic                         ram_we;
  logic [DIRS_W-1:0]            dir_rdata;
  logic [lrpc_pkg::TIME_W-1:0]  time_rdata;

  logic                         s1_valid_r;
  lrpc_pkg::s1_info_t           s1_info_r;
  logic                         pt_valid;
  lrpc_pkg::point_t             pt;

  // Configuration.
  assign cfg_ready = 1'b1;
  assign cfg_beat  = cfg_valid & cfg_ready;

  always_comb begin
    logic [lrpc_pkg::SIZE_W-1:0] sz;
    sz = cfg_data[lrpc_pkg::SIZE_W-1:0];
    if (sz == '0) begin
      eff_size_nxt = SW'(1);
    end else if (32'(sz) > PATTERN_DEPTH) begin
      eff_size_nxt = SW'(PATTERN_DEPTH);
    end else begin
      eff_size_nxt = SW'(sz);
    end
  end

  always_comb begin
    unique case (cfg_index) inside
      lrpc_pkg::REG_SCAN_STEP, lrpc_pkg::REG_SAMPLE_STRIDE, lrpc_pkg::REG_PATTERN_SIZE: begin
        reindex = 1'b1;
      end
      default: begin
        reindex = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= '0;
      max_r      <= lrpc_pkg::MAX_RANGE_RESET;
      step_r     <= '0;
      stride_r   <= lrpc_pkg::STEP_W'(1);
      eff_size_r <= EFF_RESET;
      start_r    <= 1'b0;
    end else begin
      start_r <= cfg_beat & reindex;
      if (cfg_beat) begin
        unique case (cfg_index)
          lrpc_pkg::REG_MIN_RANGE:     min_r      <= cfg_data[lrpc_pkg::RANGE_W-1:0];
          lrpc_pkg::REG_MAX_RANGE:     max_r      <= cfg_data[lrpc_pkg::RANGE_W-1:0];
          lrpc_pkg::REG_SCAN_STEP:     step_r     <= cfg_data[lrpc_pkg::STEP_W-1:0];
          lrpc_pkg::REG_SAMPLE_STRIDE: stride_r   <= cfg_data[lrpc_pkg::STEP_W-1:0];
          lrpc_pkg::REG_PATTERN_SIZE:  eff_size_r <= eff_size_nxt;
          default: begin
          end
        endcase
      end
    end
  end

  // Reduction of the indexes and increments by the pattern size.
  assign stride_eff = (stride_r == '0) ? lrpc_pkg::STEP_W'(1) : stride_r;
  assign mod_dvd[0] = DW'(ss_raw_r);
  assign mod_dvd[1] = DW'(ri_raw_r);
  assign mod_dvd[2] = DW'(stride_eff);
  assign mod_dvd[3] = DW'(step_r);

  lrpc_mod_unit #(
    .DW    (DW),
    .AW    (AW),
    .LANES (4)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .divisor  (eff_size_r),
    .dividend (mod_dvd),
    .busy     (mod_busy),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign cfg_busy = start_r | mod_busy | mod_done;

  // Input handshake and field unpacking.
  assign adv         = !pt_valid || out_tready;
  assign in_tready   = adv && !cfg_busy;
  assign in_beat     = in_tvalid & in_tready;
  assign sample_beat = in_beat && (in_tuser == lrpc_pkg::CMD_SAMPLE);
  assign entry_index = in_tdata[lrpc_pkg::IN_ENTRY_LSB +: lrpc_pkg::ENTRY_W];
  assign range_mm    = in_tdata[lrpc_pkg::IN_RANGE_LSB +: lrpc_pkg::RANGE_W];
  assign load_ok     = 32'(entry_index) < PATTERN_DEPTH;
  assign gate_pass   = (range_mm > min_r) && (range_mm < max_r);

  // Index arithmetic: every operand is already below the pattern size.
  always_comb begin
    idx_sum = {1'b0, ss_mod_r} + {1'b0, ri_mod_r};
    ss_sum  = {1'b0, ss_mod_r} + {1'b0, step_mod_r};
    ri_sum  = {1'b0, ri_mod_r} + {1'b0, stride_mod_r};
    idx     = AW'((idx_sum >= eff_size_r) ? idx_sum - eff_size_r : idx_sum);
    ss_adv  = AW'((ss_sum >= eff_size_r) ? ss_sum - eff_size_r : ss_sum);
    ri_adv  = AW'((ri_sum >= eff_size_r) ? ri_sum - eff_size_r : ri_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_raw_r     <= '0;
      ri_raw_r     <= '0;
      ss_mod_r     <= '0;
      ri_mod_r     <= '0;
      stride_mod_r <= AW'(1);
      step_mod_r   <= '0;
    end else if (mod_done) begin
      ss_mod_r     <= mod_rem[0];
      ri_mod_r     <= mod_rem[1];
      stride_mod_r <= mod_rem[2];
      step_mod_r   <= mod_rem[3];
    end else if (sample_beat) begin
      if (in_tlast) begin
        ri_mod_r <= '0;
        ri_raw_r <= '0;
        ss_mod_r <= ss_adv;
        ss_raw_r <= ss_adv;
      end else begin
        ri_mod_r <= ri_adv;
        ri_raw_r <= ri_adv;
      end
    end
  end

  // Pattern tables.
  assign ram_addr = sample_beat ? idx : AW'(entry_index);
  assign ram_we   = in_beat && (in_tuser == lrpc_pkg::CMD_LOAD) && load_ok;
  assign ram_en   = sample_beat || ram_we;

  lrpc_ram #(
    .WIDTH (DIRS_W),
    .DEPTH (PATTERN_DEPTH)
  ) u_dir_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata[lrpc_pkg::IN_DIRX_LSB +: DIRS_W]),
    .rdata (dir_rdata)
  );

  lrpc_ram #(
    .WIDTH (lrpc_pkg::TIME_W),
    .DEPTH (PATTERN_DEPTH)
  ) u_time_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata[lrpc_pkg::IN_TIME_LSB +: lrpc_pkg::TIME_W]),
    .rdata (time_rdata)
  );

  // Sample stage that waits for the table read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= sample_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_beat) begin
      s1_info_r.pass  <= gate_pass;
      s1_info_r.last  <= in_tlast;
      s1_info_r.refl  <= in_tdata[lrpc_pkg::IN_INT_LSB +: lrpc_pkg::INT_W];
      s1_info_r.range <= range_mm;
    end
  end

  lrpc_point_math #(
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_math (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_valid  (s1_valid_r),
    .s1_info   (s1_info_r),
    .dir_word  (dir_rdata),
    .time_word (time_rdata),
    .out_valid (pt_valid),
    .out_point (pt)
  );

  assign out_tvalid = pt_valid;
  assign out_tuser  = pt.pass;
  assign out_tlast  = pt.last;
  assign out_tdata  = {(lrpc_pkg::OUT_DATA_W - lrpc_pkg::OUT_USED_W)'(0),
                       pt.ptime, pt.refl, pt.z, pt.y, pt.x};

  // The input must be closed while the indexes are being reduced.
  assert property (@(posedge clk) disable iff (!rst_n) cfg_busy |-> !in_tready)
    else $error("input accepted during index reduction");

  // A table read never leaves the pattern in use.
  assert property (@(posedge clk) disable iff (!rst_n)
                   sample_beat |-> ({1'b0, idx} < eff_size_r))
    else $error("pattern index beyond pattern size");

  // Outside a reduction the scan start stays below the pattern size.
  assert property (@(posedge clk) disable iff (!rst_n)
                   !cfg_busy |-> ({1'b0, ss_mod_r} < eff_size_r))
    else $error("scan start beyond pattern size");

  // The last sample of a scan restarts the running index.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (sample_beat && in_tlast) |=> (ri_mod_r == '0))
    else $error("running index not cleared at end of scan");

endmodule

`default_nettype wire

// File: hdl/lrpc_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module lrpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/lrpc_mod_unit.sv
// Bit-serial remainder unit with parallel lanes sharing one divisor.
`default_nettype none

module lrpc_mod_unit #(
  parameter int DW    = 13,
  parameter int AW    = 13,
  parameter int LANES = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [AW:0]                divisor,
  input  wire logic [LANES-1:0][DW-1:0]   dividend,
  output logic                            busy,
  output logic                            done,
  output logic      [LANES-1:0][AW-1:0]   rem
);

  localparam int CW = $clog2(DW);

  logic                     busy_r;
  logic                     done_r;
  logic [CW-1:0]            cnt_r;
  logic [AW:0]              div_r;
  logic [LANES-1:0][DW-1:0] dvd_r;
  logic [LANES-1:0][AW-1:0] rem_r;
  logic [LANES-1:0][AW-1:0] rem_nxt;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [AW:0] trial;
      trial = {rem_r[l], dvd_r[l][DW-1]};
      if (trial >= div_r) begin
        rem_nxt[l] = AW'(trial - div_r);
      end else begin
        rem_nxt[l] = AW'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(DW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
      cnt_r <= cnt_r - 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      for (int l = 0; l < LANES; l++) begin
        dvd_r[l] <= {dvd_r[l][DW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: hdl/lrpc_point_math.sv
// Multiply, round and saturate stages that turn a range and a direction into a point.
`default_nettype none

module lrpc_point_math #(
  parameter int DIR_FRAC_BITS = 15
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            adv,
  input  wire logic                            s1_valid,
  input  wire lrpc_pkg::s1_info_t              s1_info,
  input  wire logic [3*lrpc_pkg::DIR_W-1:0]    dir_word,
  input  wire logic [lrpc_pkg::TIME_W-1:0]     time_word,
  output logic                                 out_valid,
  output lrpc_pkg::point_t                     out_point
);

  localparam int PW = lrpc_pkg::PROD_W;
  localparam int CWD = lrpc_pkg::COORD_W;
  localparam logic [PW:0] RND = (PW + 1)'(1) << (DIR_FRAC_BITS - 1);
  localparam logic signed [PW:0] CMAX = (PW + 1)'((64'd1 << (CWD - 1)) - 64'd1);
  localparam logic signed [PW:0] CMIN = -CMAX - (PW + 1)'(1);

  function automatic logic signed [CWD-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW:0] s;
    logic signed [PW:0] q;
    s = {p[PW-1], p} + $signed(RND);
    q = s >>> DIR_FRAC_BITS;
    if (q > CMAX) begin
      q = CMAX;
    end else if (q < CMIN) begin
      q = CMIN;
    end
    return q[CWD-1:0];
  endfunction

  logic signed [PW-1:0]           prod_nxt [3];
  logic signed [PW-1:0]           s2_prod_r [3];
  logic                           s2_valid_r;
  logic                           s2_pass_r;
  logic                           s2_last_r;
  logic [lrpc_pkg::INT_W-1:0]     s2_refl_r;
  logic [lrpc_pkg::TIME_W-1:0]    s2_time_r;
  logic                           out_valid_r;
  lrpc_pkg::point_t               out_point_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c] = $signed({1'b0, s1_info.range}) *
                    $signed(dir_word[c*lrpc_pkg::DIR_W +: lrpc_pkg::DIR_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s1_valid;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r <= prod_nxt;
      s2_pass_r <= s1_info.pass;
      s2_last_r <= s1_info.last;
      s2_refl_r <= s1_info.refl;
      s2_time_r <= time_word;
      out_point_r.pass <= s2_pass_r;
      out_point_r.last <= s2_last_r;
      if (s2_pass_r) begin
        out_point_r.x     <= round_sat(s2_prod_r[0]);
        out_point_r.y     <= round_sat(s2_prod_r[1]);
        out_point_r.z     <= round_sat(s2_prod_r[2]);
        out_point_r.refl  <= s2_refl_r;
        out_point_r.ptime <= s2_time_r;
      end else begin
        out_point_r.x     <= '0;
        out_point_r.y     <= '0;
        out_point_r.z     <= '0;
        out_point_r.refl  <= '0;
        out_point_r.ptime <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_point = out_point_r;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the lidar range-to-point converter with its scan pattern tables.
module tb;

  localparam int FRAC = 15;
  localparam int DEPTH = 8192;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [lrpc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [lrpc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lrpc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lrpc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lrpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lrpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lidar_range_to_point_converter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic signed [lrpc_pkg::DIR_W-1:0] tab_dx [DEPTH];
  logic signed [lrpc_pkg::DIR_W-1:0] tab_dy [DEPTH];
  logic signed [lrpc_pkg::DIR_W-1:0] tab_dz [DEPTH];
  logic [lrpc_pkg::TIME_W-1:0] tab_time [DEPTH];
  bit loaded [DEPTH];
  logic [lrpc_pkg::RANGE_W-1:0] gate_lo = '0;
  logic [lrpc_pkg::RANGE_W-1:0] gate_hi = lrpc_pkg::MAX_RANGE_RESET;
  logic [lrpc_pkg::STEP_W-1:0] scan_step = '0;
  logic [lrpc_pkg::STEP_W-1:0] stride = 13'd1;
  logic [lrpc_pkg::SIZE_W-1:0] pat_size = lrpc_pkg::SIZE_RESET;
  int unsigned scan_start = 0;
  int unsigned run_idx = 0;
  lrpc_pkg::point_t points_due [$];

  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic int unsigned cur_size();
    if (pat_size == 0) return 1;
    if (pat_size > DEPTH) return DEPTH;
    return 32'(pat_size);
  endfunction

  function automatic int unsigned next_entry();
    return (scan_start + run_idx) % cur_size();
  endfunction

  function automatic logic signed [lrpc_pkg::COORD_W-1:0] scale_dir(
      input logic [lrpc_pkg::RANGE_W-1:0] rng, input logic signed [lrpc_pkg::DIR_W-1:0] dir);
    longint q;
    q = (longint'(rng) * longint'(dir) + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (q > 16777215) q = 16777215;
    if (q < -16777216) q = -16777216;
    return q[lrpc_pkg::COORD_W-1:0];
  endfunction

  task automatic apply_cfg(input logic [lrpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lrpc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      lrpc_pkg::REG_MIN_RANGE: gate_lo = val[lrpc_pkg::RANGE_W-1:0];
      lrpc_pkg::REG_MAX_RANGE: gate_hi = val[lrpc_pkg::RANGE_W-1:0];
      lrpc_pkg::REG_SCAN_STEP: scan_step = val[lrpc_pkg::STEP_W-1:0];
      lrpc_pkg::REG_SAMPLE_STRIDE: stride = val[lrpc_pkg::STEP_W-1:0];
      lrpc_pkg::REG_PATTERN_SIZE: pat_size = val[lrpc_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic convert_to_point(input logic cmd, input logic [lrpc_pkg::IN_DATA_W-1:0] d,
                                  input logic last);
    logic [lrpc_pkg::ENTRY_W-1:0] slot;
    logic [lrpc_pkg::RANGE_W-1:0] rng;
    int unsigned sz;
    int unsigned strd;
    int unsigned idx;
    lrpc_pkg::point_t p;
    if (cmd == lrpc_pkg::CMD_LOAD) begin
      slot = d[lrpc_pkg::IN_ENTRY_LSB +: lrpc_pkg::ENTRY_W];
      tab_dx[slot] = d[lrpc_pkg::IN_DIRX_LSB +: lrpc_pkg::DIR_W];
      tab_dy[slot] = d[lrpc_pkg::IN_DIRY_LSB +: lrpc_pkg::DIR_W];
      tab_dz[slot] = d[lrpc_pkg::IN_DIRZ_LSB +: lrpc_pkg::DIR_W];
      tab_time[slot] = d[lrpc_pkg::IN_TIME_LSB +: lrpc_pkg::TIME_W];
      loaded[slot] = 1'b1;
    end else begin
      sz = cur_size();
      strd = (stride == 0) ? 1 : 32'(stride);
      idx = next_entry();
      rng = d[lrpc_pkg::IN_RANGE_LSB +: lrpc_pkg::RANGE_W];
      p = '0;
      if (rng > gate_lo && rng < gate_hi) begin
        p.pass = 1'b1;
        p.x = scale_dir(rng, tab_dx[idx]);
        p.y = scale_dir(rng, tab_dy[idx]);
        p.z = scale_dir(rng, tab_dz[idx]);
        p.refl = d[lrpc_pkg::IN_INT_LSB +: lrpc_pkg::INT_W];
        p.ptime = tab_time[idx];
      end
      p.last = last;
      points_due.insert(points_due.size(), p);
      if (last) begin
        run_idx = 0;
        scan_start = (scan_start % sz + scan_step % sz) % sz;
      end else begin
        run_idx = (run_idx % sz + strd % sz) % sz;
      end
    end
  endtask

  task automatic check_point();
    lrpc_pkg::point_t want;
    logic signed [lrpc_pkg::COORD_W-1:0] gx;
    logic signed [lrpc_pkg::COORD_W-1:0] gy;
    logic signed [lrpc_pkg::COORD_W-1:0] gz;
    if (points_due.size() == 0) begin
      report("result beat arrived with no point outstanding");
      return;
    end
    want = points_due.pop_front();
    gx = out_tdata[lrpc_pkg::OUT_X_LSB +: lrpc_pkg::COORD_W];
    gy = out_tdata[lrpc_pkg::OUT_Y_LSB +: lrpc_pkg::COORD_W];
    gz = out_tdata[lrpc_pkg::OUT_Z_LSB +: lrpc_pkg::COORD_W];
    if (out_tuser !== want.pass)
      report($sformatf("point_valid got %b want %b", out_tuser, want.pass));
    if (out_tlast !== want.last)
      report($sformatf("last_of_scan got %b want %b", out_tlast, want.last));
    if (gx !== want.x) report($sformatf("point_x got %0d want %0d", gx, want.x));
    if (gy !== want.y) report($sformatf("point_y got %0d want %0d", gy, want.y));
    if (gz !== want.z) report($sformatf("point_z got %0d want %0d", gz, want.z));
    if (out_tdata[lrpc_pkg::OUT_REFL_LSB +: lrpc_pkg::INT_W] !== want.refl)
      report($sformatf("reflectivity got %0d want %0d",
                       out_tdata[lrpc_pkg::OUT_REFL_LSB +: lrpc_pkg::INT_W], want.refl));
    if (out_tdata[lrpc_pkg::OUT_TIME_LSB +: lrpc_pkg::TIME_W] !== want.ptime)
      report($sformatf("point_time got %0h want %0h",
                       out_tdata[lrpc_pkg::OUT_TIME_LSB +: lrpc_pkg::TIME_W], want.ptime));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) convert_to_point(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_point();
    end
  end

  always @(negedge clk) begin
    if (hold_left == 0 && stall_pct != 0 && $urandom_range(99) < stall_pct)
      hold_left = $urandom_range(1, 13);
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** lidar_range_to_point_converter: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic [lrpc_pkg::IN_DATA_W-1:0] d,
                           input logic last);
    int unsigned gap;
    gap = 0;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) gap = $urandom_range(1, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= d;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [lrpc_pkg::ENTRY_W-1:0] slot,
                           input logic [lrpc_pkg::DIR_W-1:0] dx,
                           input logic [lrpc_pkg::DIR_W-1:0] dy,
                           input logic [lrpc_pkg::DIR_W-1:0] dz,
                           input logic [lrpc_pkg::TIME_W-1:0] t);
    logic [lrpc_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[lrpc_pkg::IN_ENTRY_LSB +: lrpc_pkg::ENTRY_W] = slot;
    d[lrpc_pkg::IN_DIRX_LSB +: lrpc_pkg::DIR_W] = dx;
    d[lrpc_pkg::IN_DIRY_LSB +: lrpc_pkg::DIR_W] = dy;
    d[lrpc_pkg::IN_DIRZ_LSB +: lrpc_pkg::DIR_W] = dz;
    d[lrpc_pkg::IN_TIME_LSB +: lrpc_pkg::TIME_W] = t;
    d[lrpc_pkg::IN_RANGE_LSB +: lrpc_pkg::RANGE_W] = 24'($urandom);
    d[lrpc_pkg::IN_INT_LSB +: lrpc_pkg::INT_W] = 8'($urandom);
    send_beat(lrpc_pkg::CMD_LOAD, d, 1'($urandom));
  endtask

  // The entry a sample will read is loaded first if it has never been written.
  task automatic send_sample(input logic [lrpc_pkg::RANGE_W-1:0] rng,
                             input logic [lrpc_pkg::INT_W-1:0] inten, input logic last);
    int unsigned idx;
    logic [lrpc_pkg::IN_DATA_W-1:0] d;
    idx = next_entry();
    if (!loaded[idx])
      send_load(idx[lrpc_pkg::ENTRY_W-1:0], 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom);
    d = '0;
    d[lrpc_pkg::IN_ENTRY_LSB +: lrpc_pkg::ENTRY_W] = 13'($urandom);
    d[lrpc_pkg::IN_DIRX_LSB +: lrpc_pkg::DIR_W] = 16'($urandom);
    d[lrpc_pkg::IN_DIRY_LSB +: lrpc_pkg::DIR_W] = 16'($urandom);
    d[lrpc_pkg::IN_DIRZ_LSB +: lrpc_pkg::DIR_W] = 16'($urandom);
    d[lrpc_pkg::IN_TIME_LSB +: lrpc_pkg::TIME_W] = $urandom;
    d[lrpc_pkg::IN_RANGE_LSB +: lrpc_pkg::RANGE_W] = rng;
    d[lrpc_pkg::IN_INT_LSB +: lrpc_pkg::INT_W] = inten;
    send_beat(lrpc_pkg::CMD_SAMPLE, d, last);
  endtask

  task automatic write_reg(input logic [lrpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lrpc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Loads produce no result, so the task idles on after the last point to let the last load retire.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (points_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [lrpc_pkg::RANGE_W-1:0] pick_range();
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    lo = 32'(gate_lo);
    hi = 32'(gate_hi);
    r = $urandom_range(9);
    if (r < 6 && hi > lo + 1) return 24'($urandom_range(lo + 1, hi - 1));
    if (r < 8) return r[0] ? gate_lo : gate_hi;
    return 24'($urandom);
  endfunction

  task automatic pick_setting();
    logic [lrpc_pkg::SIZE_W-1:0] sz;
    logic [lrpc_pkg::STEP_W-1:0] strd;
    logic [lrpc_pkg::STEP_W-1:0] stp;
    logic [lrpc_pkg::RANGE_W-1:0] lo;
    logic [lrpc_pkg::RANGE_W-1:0] hi;
    logic [lrpc_pkg::CFG_DATA_W-1:0] junk;
    case ($urandom_range(9))
      0: sz = '0;
      1: sz = 14'd1;
      2, 3, 4: sz = 14'($urandom_range(2, 16));
      5, 6: sz = 14'($urandom_range(17, 300));
      7: sz = 14'(DEPTH);
      8: sz = 14'($urandom_range(301, DEPTH - 1));
      default: sz = 14'($urandom_range(DEPTH + 1, 16383));
    endcase
    case ($urandom_range(4))
      0: strd = '0;
      1: strd = 13'd1;
      2: strd = 13'($urandom_range(2, 40));
      3: strd = 13'h1FFF;
      default: strd = 13'($urandom);
    endcase
    case ($urandom_range(4))
      0: stp = '0;
      1: stp = 13'($urandom_range(1, 40));
      2: stp = 13'h1FFF;
      default: stp = 13'($urandom);
    endcase
    case ($urandom_range(5))
      0, 1, 2: begin
        lo = 24'($urandom_range(0, 1000));
        hi = 24'($urandom_range(24'h100000, 24'hFFFFFF));
      end
      3: begin
        lo = '0;
        hi = 24'hFFFFFF;
      end
      4: begin
        lo = 24'($urandom);
        hi = 24'($urandom);
      end
      default: begin
        lo = 24'($urandom_range(0, 24'h7FFFFF));
        hi = lo + 24'($urandom_range(2, 5000));
      end
    endcase
    junk = ($urandom_range(3) == 0) ? 24'($urandom) : '0;
    write_reg(lrpc_pkg::REG_MIN_RANGE, lo);
    write_reg(lrpc_pkg::REG_MAX_RANGE, hi);
    write_reg(lrpc_pkg::REG_SCAN_STEP, {junk[10:0], stp});
    write_reg(lrpc_pkg::REG_SAMPLE_STRIDE, {junk[23:13], strd});
    write_reg(lrpc_pkg::REG_PATTERN_SIZE, {junk[9:0], sz});
  endtask

  task automatic run_scans(input int n_scans, input bit may_break);
    int len;
    for (int s = 0; s < n_scans; s++) begin
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0)
          send_load(($urandom_range(3) == 0) ? 13'($urandom)
                                             : 13'($urandom_range(0, cur_size() - 1)),
                    16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        send_sample(pick_range(), 8'($urandom),
                    i == len - 1 && !(may_break && s == n_scans - 1));
      end
    end
  endtask

  task automatic test_extremes();
    gap_pct = 10;
    stall_pct = 5;
    send_load(13'd0, 16'sd32767, -16'sd32768, 16'sd0, 32'hFFFF_FFFF);
    send_load(13'd1, -16'sd32768, 16'sd32767, -16'sd1, 32'h0);
    send_load(13'd2, 16'sd1, -16'sd1, 16'sd16384, 32'h1234_5678);
    send_load(13'h1FFF, -16'sd1, 16'sd1, 16'sd32767, 32'h8000_0001);
    send_sample(24'hFFFFFE, 8'hFF, 1'b0);
    send_sample(24'd1, 8'h00, 1'b0);
    send_sample(24'd16384, 8'h5A, 1'b0);
    send_sample(24'd0, 8'hA5, 1'b0);
    send_sample(24'hFFFFFF, 8'hFF, 1'b1);
    // A sample reading the entry loaded by the beat just before it.
    send_load(13'd0, -16'sd32768, -16'sd32768, -16'sd32768, 32'h0000_0001);
    send_sample(24'h800000, 8'h01, 1'b1);
  endtask

  task automatic test_range_gate();
    quiesce();
    write_reg(lrpc_pkg::REG_MIN_RANGE, 24'd100);
    write_reg(lrpc_pkg::REG_MAX_RANGE, 24'd200);
    send_sample(24'd100, 8'h11, 1'b0);
    send_sample(24'd101, 8'h22, 1'b0);
    send_sample(24'd199, 8'h33, 1'b0);
    send_sample(24'd200, 8'h44, 1'b1);
    quiesce();
    write_reg(lrpc_pkg::REG_MIN_RANGE, 24'hFFFFFF);
    write_reg(lrpc_pkg::REG_MAX_RANGE, 24'h0);
    send_sample(24'h123456, 8'h55, 1'b1);
    quiesce();
    write_reg(lrpc_pkg::REG_MIN_RANGE, 24'h0);
    write_reg(lrpc_pkg::REG_MAX_RANGE, 24'hFFFFFF);
  endtask

  task automatic test_index_corners();
    quiesce();
    write_reg(lrpc_pkg::REG_PATTERN_SIZE, 24'd0);
    write_reg(lrpc_pkg::REG_SAMPLE_STRIDE, 24'd0);
    write_reg(lrpc_pkg::REG_SCAN_STEP, 24'h1FFF);
    send_sample(24'd5000, 8'h01, 1'b0);
    send_sample(24'd6000, 8'h02, 1'b1);
    send_sample(24'd7000, 8'h03, 1'b1);
    quiesce();
    write_reg(lrpc_pkg::REG_PATTERN_SIZE, 24'h3FFF);
    write_reg(lrpc_pkg::REG_SAMPLE_STRIDE, 24'hFFE001);
    for (int i = 0; i < 3; i++) begin
      send_sample(24'd4096, 8'($urandom), 1'b0);
      send_sample(24'd8192, 8'($urandom), 1'b1);
    end
    // Leave a scan open, then shrink the pattern under it.
    quiesce();
    write_reg(lrpc_pkg::REG_PATTERN_SIZE, 24'd8192);
    write_reg(lrpc_pkg::REG_SAMPLE_STRIDE, 24'h1FFF);
    send_sample(24'd300, 8'h10, 1'b0);
    send_sample(24'd400, 8'h20, 1'b0);
    quiesce();
    write_reg(lrpc_pkg::REG_PATTERN_SIZE, 24'd5);
    write_reg(REG_SPARE_LO, 24'hFFFFFF);
    write_reg(REG_SPARE_HI, 24'hFFFFFF);
    send_sample(24'd500, 8'h30, 1'b0);
    send_sample(24'd600, 8'h40, 1'b1);
  endtask

  task automatic test_random_scans(input int n_samples);
    int n_runs;
    int pct_sel;
    for (int sent = 0; sent < n_samples; ) begin
      quiesce();
      pct_sel = $urandom_range(2);
      gap_pct = (pct_sel == 0) ? 0 : (pct_sel == 1) ? 10 : 35;
      stall_pct = (pct_sel == 0) ? 0 : (pct_sel == 1) ? 3 : 12;
      pick_setting();
      n_runs = $urandom_range(2, 6);
      for (int s = 0; s < n_runs; s++) begin
        run_scans(1, s == n_runs - 1 && $urandom_range(4) == 0);
      end
      sent += n_runs * 15;
    end
  endtask

  task automatic test_back_to_back();
    quiesce();
    gap_pct = 0;
    stall_pct = 0;
    write_reg(lrpc_pkg::REG_MIN_RANGE, 24'd10);
    write_reg(lrpc_pkg::REG_MAX_RANGE, 24'hFFFFF0);
    write_reg(lrpc_pkg::REG_SCAN_STEP, 24'd7);
    write_reg(lrpc_pkg::REG_SAMPLE_STRIDE, 24'd3);
    write_reg(lrpc_pkg::REG_PATTERN_SIZE, 24'd97);
    run_scans(10, 1'b0);
  endtask

  initial begin
    int spin;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_range_gate();
    test_index_corners();
    test_random_scans(1000);
    test_back_to_back();
    in_tvalid <= 1'b0;
    spin = 0;
    while (points_due.size() != 0 && spin < 20000) begin
      @(negedge clk);
      spin++;
    end
    repeat (10) @(negedge clk);
    if (points_due.size() != 0)
      report($sformatf("%0d points never arrived", points_due.size()));
    if (errors == 0) begin
      $display("** lidar_range_to_point_converter: PASSED **");
    end else begin
      $display("** lidar_range_to_point_converter: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/lrpc_pkg.sv
hdl/lrpc_ram.sv
hdl/lrpc_mod_unit.sv
hdl/lrpc_point_math.sv
hdl/lidar_range_to_point_converter.sv
sim/tb.sv
